### src/srps_pkg.sv
// Shared types and constants of the rare-position search block.
`default_nettype none

package srps_pkg;

   localparam int IND_W = 8;
   localparam int POS_W = 31;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [IND_W-1:0] individual_a;
      logic [IND_W-1:0] individual_b;
      logic [POS_W-1:0] position;
      logic             search_backward;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] shared_position;
      logic             status;
   } rsp_type;

endpackage

`default_nettype wire

### src/shared_rare_position_search_core.sv
// Top level of the shared rare-position search block: sequencer, list storage, result register.
//
// Usage: a transaction on the req_ channel carries one operation. Append adds a
// position to the end of one individual's list (status is 1 when the list is
// already full and the append is dropped), query looks for the first position
// that two lists share at or beyond a start position in the chosen direction,
// and clear empties every list at once. Every request transaction produces
// exactly one transaction on the rsp_ channel.
//
// Timing: the block handles one request at a time and req_ready is high only
// while it is idle. A clear or an unused operation goes straight to the done
// state; an append first reads the list's count. A query reads both counts
// and then walks both lists through the single read port of the position
// memory, one entry per cycle with one compare per cycle, so its run time
// grows with the two list lengths na and nb.
//
// The finished result sits in an output register. If the receiver stalls, the
// block holds the result until rsp_ready is seen; a new request can still be
// taken meanwhile. Reset empties all lists by clearing the per-list valid
// bits of the count store; the position memory itself is never cleared.
`default_nettype none

module shared_rare_position_search_core
   import srps_pkg::*;
#(
   parameter int NUM_INDIVIDUALS    = 256,
   parameter int MAX_PER_INDIVIDUAL = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // Only 256 individuals can be named by the request fields.
   localparam int NUM_LISTS = (NUM_INDIVIDUALS < 256) ? NUM_INDIVIDUALS : 256;
   localparam int LIST_W    = $clog2(NUM_LISTS);
   localparam int CNT_W     = $clog2(MAX_PER_INDIVIDUAL + 1);
   localparam int POS_DEPTH = NUM_LISTS * MAX_PER_INDIVIDUAL;
   localparam int POS_AW    = $clog2(POS_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CNT_A,
      ST_CNT_B,
      ST_CNT_CHK,
      ST_APPEND,
      ST_LOAD_B,
      ST_SKIP_B,
      ST_SKIP_A,
      ST_WALK,
      ST_DONE
   } state_type;

   // Sequencer state and per-transaction context.
   state_type          state_ff, state_in;
   logic               is_query_ff, is_query_in;
   logic               back_ff, back_in;
   logic [LIST_W-1:0]  a_idx_ff, a_idx_in;
   logic [LIST_W-1:0]  b_idx_ff, b_idx_in;
   logic [POS_AW-1:0]  base_a_ff, base_a_in;
   logic [POS_AW-1:0]  base_b_ff, base_b_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   na_ff, na_in;
   logic [CNT_W-1:0]   nb_ff, nb_in;
   logic [CNT_W-1:0]   pa_ff, pa_in;
   logic [CNT_W-1:0]   pb_ff, pb_in;
   logic [POS_W-1:0]   va_ff, va_in;
   logic [POS_W-1:0]   vb_ff, vb_in;
   logic               pend_a_ff, pend_a_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [NUM_LISTS-1:0] cnt_valid_ff, cnt_valid_in;

   // Storage: list contents and list lengths.
   logic [POS_W-1:0]   pos_mem [POS_DEPTH];
   logic [POS_W-1:0]   pos_rdata_ff;
   logic [CNT_W-1:0]   cnt_mem [NUM_LISTS];
   logic [CNT_W-1:0]   cnt_rdata_ff;
   logic               cnt_rvalid_ff;

   logic               pos_we;
   logic [POS_AW-1:0]  pos_waddr;
   logic [POS_AW-1:0]  pos_raddr;
   logic               cnt_we;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [LIST_W-1:0]  cnt_raddr;

   // Read address selection for the position memory.
   logic               rd_sel_b;
   logic [CNT_W-1:0]   rd_idx;

   // Pointer helpers. Forward, a pointer is the index of the current entry;
   // backward, it is the number of entries still left, so the current entry
   // sits one below it.
   logic [CNT_W-1:0]   count_rd;
   logic [CNT_W-1:0]   pa_cur, pa_nxt, pa_step;
   logic [CNT_W-1:0]   pb_cur, pb_nxt, pb_step;
   logic               pa_live, pb_live, pa_step_live, pb_step_live;
   logic [POS_W-1:0]   va, vb;
   logic [POS_W-1:0]   cmp_lhs, cmp_rhs;
   logic               cmp_ahead, cmp_same;
   logic               b_first, a_first;
   logic               a_ok, b_ok;

   assign count_rd = cnt_rvalid_ff ? cnt_rdata_ff : '0;

   assign pa_cur  = back_ff ? pa_ff - CNT_W'(1) : pa_ff;
   assign pa_nxt  = back_ff ? pa_ff - CNT_W'(2) : pa_ff + CNT_W'(1);
   assign pa_step = back_ff ? pa_ff - CNT_W'(1) : pa_ff + CNT_W'(1);
   assign pb_cur  = back_ff ? pb_ff - CNT_W'(1) : pb_ff;
   assign pb_nxt  = back_ff ? pb_ff - CNT_W'(2) : pb_ff + CNT_W'(1);
   assign pb_step = back_ff ? pb_ff - CNT_W'(1) : pb_ff + CNT_W'(1);

   assign pa_live      = back_ff ? (pa_ff != '0)   : (pa_ff != na_ff);
   assign pb_live      = back_ff ? (pb_ff != '0)   : (pb_ff != nb_ff);
   assign pa_step_live = back_ff ? (pa_step != '0) : (pa_step != na_ff);
   assign pb_step_live = back_ff ? (pb_step != '0) : (pb_step != nb_ff);

   // During the walk, one list's current value has just come out of the
   // memory and the other is held in its register.
   assign va = pend_a_ff ? pos_rdata_ff : va_ff;
   assign vb = pend_a_ff ? vb_ff : pos_rdata_ff;

   // The comparator serves the skip phases (entry against start) and the
   // walk (list b against list a).
   assign cmp_lhs = (state_ff == ST_WALK) ? vb : pos_rdata_ff;
   assign cmp_rhs = (state_ff == ST_WALK) ? va : start_ff;

   srps_cmp u_cmp (
      .lhs      (cmp_lhs),
      .rhs      (cmp_rhs),
      .backward (back_ff),
      .ahead    (cmp_ahead),
      .same     (cmp_same)
   );

   assign b_first = cmp_ahead;
   assign a_first = !cmp_ahead && !cmp_same;

   assign a_ok = (32'(req_payload.individual_a) < 32'(NUM_INDIVIDUALS));
   assign b_ok = (32'(req_payload.individual_b) < 32'(NUM_INDIVIDUALS));

   assign pos_raddr = (rd_sel_b ? base_b_ff : base_a_ff) + POS_AW'(rd_idx);
   assign pos_waddr = base_a_ff + POS_AW'(count_rd);
   assign cnt_raddr = (state_ff == ST_CNT_B) ? b_idx_ff : a_idx_ff;
   assign cnt_wdata = count_rd + CNT_W'(1);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      is_query_in  = is_query_ff;
      back_in      = back_ff;
      a_idx_in     = a_idx_ff;
      b_idx_in     = b_idx_ff;
      base_a_in    = base_a_ff;
      base_b_in    = base_b_ff;
      start_in     = start_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      pend_a_in    = pend_a_ff;
      res_in       = res_ff;
      cnt_valid_in = cnt_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pos_we       = 1'b0;
      cnt_we       = 1'b0;
      rd_sel_b     = 1'b0;
      rd_idx       = pa_cur;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               is_query_in = (req_payload.operation == OP_QUERY);
               back_in     = req_payload.search_backward;
               a_idx_in    = LIST_W'(req_payload.individual_a);
               b_idx_in    = LIST_W'(req_payload.individual_b);
               base_a_in   = POS_AW'(LIST_W'(req_payload.individual_a)) *
                             POS_AW'(MAX_PER_INDIVIDUAL);
               base_b_in   = POS_AW'(LIST_W'(req_payload.individual_b)) *
                             POS_AW'(MAX_PER_INDIVIDUAL);
               start_in    = req_payload.position;
               res_in      = '0;
               state_in    = ST_DONE;
               case (req_payload.operation)
                  OP_APPEND: begin
                     if (a_ok) begin
                        state_in = ST_CNT_A;
                     end
                  end
                  OP_QUERY: begin
                     if (a_ok && b_ok) begin
                        state_in = ST_CNT_A;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CNT_A: begin
            state_in = is_query_ff ? ST_CNT_B : ST_APPEND;
         end
         ST_APPEND: begin
            if (count_rd == CNT_W'(MAX_PER_INDIVIDUAL)) begin
               res_in.status = 1'b1;
            end else begin
               pos_we                 = 1'b1;
               cnt_we                 = 1'b1;
               cnt_valid_in[a_idx_ff] = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_CNT_B: begin
            na_in    = count_rd;
            state_in = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            nb_in = count_rd;
            if (na_ff == '0 || count_rd == '0) begin
               state_in = ST_DONE;
            end else begin
               pa_in    = back_ff ? na_ff : '0;
               pb_in    = back_ff ? count_rd : '0;
               state_in = ST_LOAD_B;
            end
         end
         ST_LOAD_B: begin
            rd_sel_b = 1'b1;
            rd_idx   = pb_cur;
            state_in = ST_SKIP_B;
         end
         ST_SKIP_B: begin
            // Skip list b entries that lie before the start.
            if (pb_live && cmp_ahead) begin
               pb_in    = pb_step;
               rd_sel_b = 1'b1;
               rd_idx   = pb_nxt;
            end else if (!pb_live) begin
               state_in = ST_DONE;
            end else begin
               vb_in    = pos_rdata_ff;
               rd_idx   = pa_cur;
               state_in = ST_SKIP_A;
            end
         end
         ST_SKIP_A: begin
            if (pa_live && cmp_ahead) begin
               pa_in  = pa_step;
               rd_idx = pa_nxt;
            end else if (!pa_live) begin
               state_in = ST_DONE;
            end else begin
               // Re-read the current entry so that it is on the read port
               // when the walk starts.
               rd_idx    = pa_cur;
               pend_a_in = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            // Advance whichever list is behind; equal values are the answer.
            if (b_first) begin
               va_in = va;
               pb_in = pb_step;
               if (!pb_step_live) begin
                  state_in = ST_DONE;
               end else begin
                  rd_sel_b  = 1'b1;
                  rd_idx    = pb_nxt;
                  pend_a_in = 1'b0;
               end
            end else if (a_first) begin
               vb_in = vb;
               pa_in = pa_step;
               if (!pa_step_live) begin
                  state_in = ST_DONE;
               end else begin
                  rd_idx    = pa_nxt;
                  pend_a_in = 1'b1;
               end
            end else begin
               res_in.found           = 1'b1;
               res_in.shared_position = va;
               state_in               = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_valid_ff <= cnt_valid_in;
      end
      is_query_ff <= is_query_in;
      back_ff     <= back_in;
      a_idx_ff    <= a_idx_in;
      b_idx_ff    <= b_idx_in;
      base_a_ff   <= base_a_in;
      base_b_ff   <= base_b_in;
      start_ff    <= start_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      pend_a_ff   <= pend_a_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Position memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= start_ff;
      end
      pos_rdata_ff <= pos_mem[pos_raddr];
   end

   // Count memory; a list whose valid bit is clear reads as empty.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[a_idx_ff] <= cnt_wdata;
      end
      cnt_rdata_ff  <= cnt_mem[cnt_raddr];
      cnt_rvalid_ff <= cnt_valid_ff[cnt_raddr];
   end

endmodule

`default_nettype wire

### src/srps_cmp.sv
// Direction-aware position comparator shared by every search step.
`default_nettype none

module srps_cmp
   import srps_pkg::*;
(
   input  wire logic [POS_W-1:0] lhs,
   input  wire logic [POS_W-1:0] rhs,
   input  wire logic             backward,
   output logic                  ahead,
   output logic                  same
);

   // "Ahead" means lhs comes earlier in the walking order than rhs.
   always_comb begin
      same  = (lhs == rhs);
      ahead = backward ? (lhs > rhs) : (lhs < rhs);
   end

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench of the shared rare-position search block.
`default_nettype none

module testbench
   import srps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_INDIVIDUALS    = 256;
   localparam int MAX_PER_INDIVIDUAL = 64;

   // The package names only the three live operations; the fourth encoding is a no-op.
   localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
   localparam logic [POS_W-1:0] POS_MAX   = '1;

   // A query walks at most both full lists. With random receiver stalls and
   // sender gaps on top, the 1602 transactions of the run stay well below this bound.
   localparam int CYCLE_LIMIT = 2_000_000;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Both sides insert random idle cycles while this is set.
   bit idling_on = 1'b1;
   bit mismatch_seen = 1'b0;
   int cycle_count = 0;

   // Mirror of the block's list storage, used by the predictor.
   logic [POS_W-1:0] list_positions [NUM_INDIVIDUALS][MAX_PER_INDIVIDUAL];
   int unsigned      list_lengths   [NUM_INDIVIDUALS];

   // Responses predicted at request acceptance, oldest first.
   rsp_type expected_responses [$];

   // State of the random traffic generator: a small pool of individuals whose
   // lists share a narrow position window, so that queries actually find matches.
   int               pool_first;
   int               pool_size;
   logic [POS_W-1:0] pool_base;
   int unsigned      pool_tail [NUM_INDIVIDUALS];
   int unsigned      pool_span;

   shared_rare_position_search_core #(
      .NUM_INDIVIDUALS    (NUM_INDIVIDUALS),
      .MAX_PER_INDIVIDUAL (MAX_PER_INDIVIDUAL)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The receiver stalls at random, with a probability of about 29 percent, unless
   // idling is switched off for a back-to-back stretch.
   always @(posedge clock) begin
      if (idling_on) begin
         rsp_ready <= ($urandom_range(99) >= 29);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Two-pointer walk over both lists, exactly as the hardware walks them, so
   // that lists appended out of order give the same answer as in the block.
   function automatic rsp_type search_shared(input logic [IND_W-1:0] ind_a,
                                             input logic [IND_W-1:0] ind_b,
                                             input logic [POS_W-1:0] start,
                                             input logic backward);
      rsp_type     result;
      int unsigned len_a;
      int unsigned len_b;
      int unsigned ia;
      int unsigned ib;
      logic [POS_W-1:0] va;
      logic [POS_W-1:0] vb;
      result = '0;
      len_a  = list_lengths[ind_a];
      len_b  = list_lengths[ind_b];
      if (len_a == 0 || len_b == 0) begin
         return result;
      end
      if (backward) begin
         // Pointers count the remaining entries; the current one is at index - 1.
         ia = len_a;
         ib = len_b;
         while (ib > 0 && list_positions[ind_b][ib-1] > start) ib--;
         while (ia > 0 && list_positions[ind_a][ia-1] > start) ia--;
         while (ia > 0 && ib > 0 && !result.found) begin
            va = list_positions[ind_a][ia-1];
            vb = list_positions[ind_b][ib-1];
            if (vb > va) begin
               ib--;
            end else if (va > vb) begin
               ia--;
            end else begin
               result.found           = 1'b1;
               result.shared_position = va;
            end
         end
      end else begin
         ia = 0;
         ib = 0;
         while (ib < len_b && list_positions[ind_b][ib] < start) ib++;
         while (ia < len_a && list_positions[ind_a][ia] < start) ia++;
         while (ia < len_a && ib < len_b && !result.found) begin
            va = list_positions[ind_a][ia];
            vb = list_positions[ind_b][ib];
            if (vb < va) begin
               ib++;
            end else if (va < vb) begin
               ia++;
            end else begin
               result.found           = 1'b1;
               result.shared_position = va;
            end
         end
      end
      return result;
   endfunction

   // Applies one request to the mirrored lists and returns the response the
   // block must give for it.
   function automatic rsp_type predict_response(input req_type item);
      rsp_type     result;
      int unsigned len;
      result = '0;
      case (item.operation)
         OP_APPEND: begin
            len = list_lengths[item.individual_a];
            if (len >= MAX_PER_INDIVIDUAL) begin
               result.status = 1'b1;
            end else begin
               list_positions[item.individual_a][len] = item.position;
               list_lengths[item.individual_a]        = len + 1;
            end
         end
         OP_QUERY: begin
            result = search_shared(item.individual_a, item.individual_b,
                                   item.position, item.search_backward);
         end
         OP_CLEAR: begin
            foreach (list_lengths[i]) list_lengths[i] = 0;
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   function automatic req_type make_request(input logic [OP_W-1:0]  operation,
                                            input logic [IND_W-1:0] ind_a,
                                            input logic [IND_W-1:0] ind_b,
                                            input logic [POS_W-1:0] position,
                                            input logic             backward);
      req_type item;
      item.operation       = operation;
      item.individual_a    = ind_a;
      item.individual_b    = ind_b;
      item.position        = position;
      item.search_backward = backward;
      return item;
   endfunction

   // Picks a fresh pool of individuals and a fresh position window.
   function automatic void start_new_pool();
      pool_first = $urandom_range(NUM_INDIVIDUALS - 1);
      pool_size  = $urandom_range(6, 2);
      pool_base  = ($urandom_range(3) == 0) ? '0 : POS_W'($urandom_range(32'h7FFF_0000));
      pool_span  = 0;
      foreach (pool_tail[i]) pool_tail[i] = 0;
   endfunction

   function automatic logic [IND_W-1:0] pool_member();
      return IND_W'(pool_first + $urandom_range(pool_size - 1));
   endfunction

   // Mostly well-formed traffic on the pool: ascending appends with frequent
   // duplicates across individuals, queries that start inside the window, and
   // rare clears. The rest is out-of-order appends and fully random noise.
   function automatic req_type random_request();
      req_type          item;
      int               roll;
      logic [IND_W-1:0] owner;
      int unsigned      offset;
      item = '{operation: OP_UNUSED, individual_a: IND_W'($urandom()),
               individual_b: IND_W'($urandom()), position: POS_W'($urandom()),
               search_backward: 1'($urandom_range(1))};
      roll = $urandom_range(999);
      if (roll < 3) begin
         item.operation = OP_CLEAR;
         start_new_pool();
      end else if (roll < 600) begin
         owner = pool_member();
         if ($urandom_range(19) == 0) begin
            offset = $urandom_range(pool_span + 4);
         end else begin
            pool_tail[owner] += $urandom_range(3);
            offset = pool_tail[owner];
         end
         if (offset > pool_span) pool_span = offset;
         item.operation    = OP_APPEND;
         item.individual_a = owner;
         item.position     = pool_base + POS_W'(offset);
      end else if (roll < 920) begin
         item.operation    = OP_QUERY;
         item.individual_a = pool_member();
         item.individual_b = pool_member();
         case ($urandom_range(9))
            0:       item.position = '0;
            1:       item.position = POS_MAX;
            default: item.position = pool_base + POS_W'($urandom_range(pool_span + 3));
         endcase
      end else begin
         // Noise: any operation but clear, with every field random.
         case ($urandom_range(2))
            0:       item.operation = OP_APPEND;
            1:       item.operation = OP_QUERY;
            default: item.operation = OP_UNUSED;
         endcase
      end
      return item;
   endfunction

   // Sends one request transaction. A sender gap, when one is drawn, drops
   // valid for a random number of cycles before the item is presented; valid
   // then stays high with a stable payload until req_ready is seen at an edge.
   task automatic send_request(input req_type item);
      if (idling_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 29);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      expected_responses = {expected_responses, predict_response(item)};
   endtask

   task automatic wait_for_responses();
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   // Every response transaction is checked against the oldest prediction.
   // Outputs are sampled at the rising edge, before the block updates them.
   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            $error("response transaction with no request pending");
            mismatch_seen = 1'b1;
         end else begin
            expected = expected_responses.pop_front();
            if (rsp_payload.found !== expected.found) begin
               $error("found: expected %0d, actual %0d", expected.found, rsp_payload.found);
               mismatch_seen = 1'b1;
            end
            if (rsp_payload.shared_position !== expected.shared_position) begin
               $error("shared_position: expected %0h, actual %0h",
                      expected.shared_position, rsp_payload.shared_position);
               mismatch_seen = 1'b1;
            end
            if (rsp_payload.status !== expected.status) begin
               $error("status: expected %0d, actual %0d", expected.status, rsp_payload.status);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   // Queries on lists that are still empty, and one list filled against one empty.
   task automatic test_empty_lists();
      send_request(make_request(OP_QUERY, 8'd0, 8'd255, '0, 1'b0));
      send_request(make_request(OP_QUERY, 8'd255, 8'd0, POS_MAX, 1'b1));
      send_request(make_request(OP_APPEND, 8'd0, 8'd0, '0, 1'b0));
      send_request(make_request(OP_QUERY, 8'd0, 8'd1, '0, 1'b0));
   endtask

   // Lowest and highest individuals and positions, in both directions.
   task automatic test_field_extremes();
      send_request(make_request(OP_APPEND, 8'd1, 8'd255, '0, 1'b1));
      send_request(make_request(OP_APPEND, 8'd255, 8'd0, POS_MAX, 1'b0));
      send_request(make_request(OP_APPEND, 8'd254, 8'd255, POS_MAX, 1'b1));
      send_request(make_request(OP_QUERY, 8'd0, 8'd1, '0, 1'b0));
      send_request(make_request(OP_QUERY, 8'd0, 8'd1, POS_MAX, 1'b1));
      send_request(make_request(OP_QUERY, 8'd255, 8'd254, POS_MAX, 1'b0));
      send_request(make_request(OP_QUERY, 8'd254, 8'd255, '0, 1'b1));
      send_request(make_request(OP_QUERY, 8'd255, 8'd254, POS_MAX, 1'b1));
      send_request(make_request(OP_QUERY, 8'd0, 8'd255, '0, 1'b0));
   endtask

   // Lists appended out of order: the walk must stop where the block stops.
   task automatic test_unsorted_lists();
      send_request(make_request(OP_APPEND, 8'd2, 8'd0, 31'd50, 1'b0));
      send_request(make_request(OP_APPEND, 8'd2, 8'd0, 31'd10, 1'b0));
      send_request(make_request(OP_APPEND, 8'd3, 8'd0, 31'd10, 1'b0));
      send_request(make_request(OP_APPEND, 8'd3, 8'd0, 31'd50, 1'b0));
      send_request(make_request(OP_QUERY, 8'd2, 8'd3, '0, 1'b0));
      send_request(make_request(OP_QUERY, 8'd2, 8'd3, 31'd60, 1'b1));
      send_request(make_request(OP_QUERY, 8'd3, 8'd2, 31'd10, 1'b0));
   endtask

   // The unused operation with every field set, then a clear that must empty
   // the lists that matched before.
   task automatic test_unused_and_clear();
      send_request(make_request(OP_UNUSED, '1, '1, POS_MAX, 1'b1));
      send_request(make_request(OP_CLEAR, 8'd0, 8'd0, '0, 1'b0));
      send_request(make_request(OP_QUERY, 8'd255, 8'd254, POS_MAX, 1'b1));
   endtask

   // Fills one list to capacity, overflows it twice, and searches it against a
   // sparse list that shares some of its entries.
   task automatic test_full_list();
      logic [IND_W-1:0] full_owner;
      logic [IND_W-1:0] sparse_owner;
      logic [POS_W-1:0] base;
      full_owner   = IND_W'($urandom());
      sparse_owner = full_owner ^ IND_W'($urandom_range(255, 1));
      base         = POS_W'($urandom_range(32'h7FFF_F000));
      send_request(make_request(OP_CLEAR, IND_W'($urandom()), IND_W'($urandom()),
                                POS_W'($urandom()), 1'b0));
      for (int k = 0; k < MAX_PER_INDIVIDUAL + 2; k++) begin
         send_request(make_request(OP_APPEND, full_owner, IND_W'($urandom()),
                                   base + POS_W'(2 * k), 1'($urandom_range(1))));
      end
      for (int k = 3; k < MAX_PER_INDIVIDUAL; k += 9) begin
         send_request(make_request(OP_APPEND, sparse_owner, IND_W'($urandom()),
                                   base + POS_W'(2 * k + (k % 2)), 1'b0));
      end
      send_request(make_request(OP_QUERY, full_owner, sparse_owner, base, 1'b0));
      send_request(make_request(OP_QUERY, sparse_owner, full_owner, POS_MAX, 1'b1));
      send_request(make_request(OP_QUERY, full_owner, sparse_owner,
                                base + POS_W'($urandom_range(130)), 1'b0));
      send_request(make_request(OP_QUERY, sparse_owner, full_owner,
                                base + POS_W'($urandom_range(130)), 1'b1));
      send_request(make_request(OP_QUERY, full_owner, full_owner, base + 31'd77, 1'b1));
   endtask

   // A long stretch in which neither side ever idles.
   task automatic test_back_to_back(input int count);
      idling_on = 1'b0;
      start_new_pool();
      repeat (count) send_request(random_request());
      // The last transaction has been taken; drop valid so it is not sent twice.
      req_valid <= 1'b0;
      wait_for_responses();
      idling_on = 1'b1;
   endtask

   // The bulk of the run: random traffic with idling on both sides.
   task automatic test_random_traffic(input int count);
      start_new_pool();
      repeat (count) send_request(random_request());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_lists();
      test_field_extremes();
      test_unsorted_lists();
      test_unused_and_clear();
      test_full_list();
      test_back_to_back(300);
      test_random_traffic(1200);

      req_valid <= 1'b0;
      wait_for_responses();
      repeat (10) @(posedge clock);
      if (!mismatch_seen) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

### shared_rare_position_search_core.f
src/srps_pkg.sv
src/srps_cmp.sv
src/shared_rare_position_search_core.sv
sim/testbench.sv
